// ===== rtl/bdpc_pkg.sv =====
// Shared types and constants for the button debounce press classifier.
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

   // Width of the threshold registers and of the reported duration.
   localparam int unsigned THR_WIDTH = 16;

   // Register indexes, taken from address bit 2 of the configuration port.
   localparam logic REG_DEBOUNCE_TICKS   = 1'b0;
   localparam logic REG_LONG_PRESS_TICKS = 1'b1;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_SHORT = 2'd1,
      EVT_LONG  = 2'd2
   } press_event_type;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_press_classifier.sv =====
// Button debounce and short/long press classifier, top level.
`timescale 1ns / 1ps
`default_nettype none

// Each req item is one tick of the raw active-low button level. It returns exactly one
// rsp item with the press event (none, short on release, long while held), the
// debounced held state and the held duration, saturated to 16 bits. A level is taken
// once it has stayed unchanged for more than debounce_ticks ticks. The block takes one
// item per clock while the result side is ready: the classification is a single pass of
// counters and compares into the result register, which refills in the same cycle it is taken.
// The stable and duration counters are COUNT_WIDTH bits wide and saturate. Thresholds
// are written through the APB port at 0x0 (debounce_ticks) and 0x4 (long_press_ticks).
module button_debounce_press_classifier
   import bdpc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // tick input
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic                 req_raw_level,
   // result output
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [1:0]           rsp_press_event,
   output      logic                 rsp_is_held,
   output      logic [THR_WIDTH-1:0] rsp_held_ticks,
   // configuration
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output      logic [31:0]          prdata,
   output      logic                 pready
);

   localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [CMP_WIDTH-1:0]   HELD_MAX = CMP_WIDTH'({THR_WIDTH{1'b1}});

   // configuration registers
   logic [THR_WIDTH-1:0]   debounce_ticks_ff;
   logic [THR_WIDTH-1:0]   long_press_ticks_ff;

   // tick state
   logic                   previous_raw_ff, previous_raw_in;
   logic [COUNT_WIDTH-1:0] stable_count_ff, stable_count_in;
   logic                   debounced_level_ff, debounced_level_in;
   logic                   held_flag_ff, held_flag_in;
   logic                   long_reported_ff, long_reported_in;
   logic [COUNT_WIDTH-1:0] duration_count_ff, duration_count_in;

   // result register
   logic                   rsp_valid_ff;
   press_event_type        rsp_event_ff, rsp_event_in;
   logic                   rsp_held_ff;
   logic [THR_WIDTH-1:0]   rsp_ticks_ff, rsp_ticks_in;

   logic                   accept;
   logic                   csr_write;
   logic [COUNT_WIDTH-1:0] duration_step;
   logic [CMP_WIDTH-1:0]   stable_ext;
   logic [CMP_WIDTH-1:0]   duration_ext;
   logic [CMP_WIDTH-1:0]   duration_next_ext;
   logic [CMP_WIDTH-1:0]   debounce_ext;
   logic [CMP_WIDTH-1:0]   long_ext;
   logic                   level_change;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         REG_DEBOUNCE_TICKS:   prdata = 32'(debounce_ticks_ff);
         REG_LONG_PRESS_TICKS: prdata = 32'(long_press_ticks_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= THR_WIDTH'(50);
         long_press_ticks_ff <= THR_WIDTH'(1000);
      end else if (csr_write) begin
         case (paddr[2])
            REG_DEBOUNCE_TICKS:   debounce_ticks_ff   <= pwdata[THR_WIDTH-1:0];
            REG_LONG_PRESS_TICKS: long_press_ticks_ff <= pwdata[THR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Take a new item whenever the result register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      debounce_ext = CMP_WIDTH'(debounce_ticks_ff);
      long_ext     = CMP_WIDTH'(long_press_ticks_ff);

      // advance the held duration first, saturating
      duration_step = duration_count_ff;
      if (held_flag_ff && (duration_count_ff != CNT_MAX)) begin
         duration_step = duration_count_ff + COUNT_WIDTH'(1);
      end
      duration_ext = CMP_WIDTH'(duration_step);

      // a changed level restarts the stability count
      if (req_raw_level != previous_raw_ff) begin
         stable_count_in = '0;
      end else if (stable_count_ff != CNT_MAX) begin
         stable_count_in = stable_count_ff + COUNT_WIDTH'(1);
      end else begin
         stable_count_in = stable_count_ff;
      end
      stable_ext      = CMP_WIDTH'(stable_count_in);
      previous_raw_in = req_raw_level;

      debounced_level_in = debounced_level_ff;
      held_flag_in       = held_flag_ff;
      long_reported_in   = long_reported_ff;
      duration_count_in  = duration_step;
      rsp_event_in       = EVT_NONE;

      level_change = (stable_ext > debounce_ext) && (req_raw_level != debounced_level_ff);
      if (level_change) begin
         debounced_level_in = req_raw_level;
         long_reported_in   = 1'b0;
         duration_count_in  = '0;
         if (!req_raw_level) begin
            held_flag_in = 1'b1;
         end else begin
            if (held_flag_ff && !long_reported_ff &&
                (duration_ext > debounce_ext) && (duration_ext < long_ext)) begin
               rsp_event_in = EVT_SHORT;
            end
            held_flag_in = 1'b0;
         end
      end

      duration_next_ext = CMP_WIDTH'(duration_count_in);
      if (held_flag_in && !long_reported_in && (duration_next_ext >= long_ext)) begin
         long_reported_in = 1'b1;
         rsp_event_in     = EVT_LONG;
      end

      // show zero when released, clamp to the 16-bit field when held
      if (!held_flag_in) begin
         rsp_ticks_in = '0;
      end else if (duration_next_ext > HELD_MAX) begin
         rsp_ticks_in = {THR_WIDTH{1'b1}};
      end else begin
         rsp_ticks_in = duration_next_ext[THR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff    <= 1'b1;
         stable_count_ff    <= '0;
         debounced_level_ff <= 1'b1;
         held_flag_ff       <= 1'b0;
         long_reported_ff   <= 1'b0;
         duration_count_ff  <= '0;
      end else if (accept) begin
         previous_raw_ff    <= previous_raw_in;
         stable_count_ff    <= stable_count_in;
         debounced_level_ff <= debounced_level_in;
         held_flag_ff       <= held_flag_in;
         long_reported_ff   <= long_reported_in;
         duration_count_ff  <= duration_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff <= rsp_event_in;
         rsp_held_ff  <= held_flag_in;
         rsp_ticks_ff <= rsp_ticks_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_event = rsp_event_ff;
   assign rsp_is_held     = rsp_held_ff;
   assign rsp_held_ticks  = rsp_ticks_ff;

   // a released button never reports a duration
   a_released_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_held_ff) |-> (rsp_ticks_ff == '0))
      else $error("held_ticks nonzero while released");

   // a long press only comes while held, a short press only on release
   a_long_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_ff == EVT_LONG)) |-> rsp_held_ff)
      else $error("long press reported while released");

   a_short_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_ff == EVT_SHORT)) |-> !rsp_held_ff)
      else $error("short press reported while held");

   // the held flag and the debounced level always agree
   a_held_level: assert property (@(posedge clock) disable iff (reset)
      held_flag_ff == !debounced_level_ff)
      else $error("held flag out of step with debounced level");

endmodule

`default_nettype wire

// ===== bench/button_debounce_press_classifier_tb.sv =====
// Self-checking testbench for the button debounce press classifier.
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb;
   import bdpc_pkg::*;

   localparam int STALL_LIMIT = 1000;

   typedef struct {
      press_event_type      evt;
      logic                 held;
      logic [THR_WIDTH-1:0] ticks;
   } press_result_type;

   // Tracks debounce and press state per tick and holds the expected results in order.
   class press_scoreboard;
      logic [THR_WIDTH-1:0] debounce_thr;
      logic [THR_WIDTH-1:0] long_thr;
      logic                 prev_raw;
      logic                 debounced;
      logic                 held;
      logic                 long_done;
      logic [15:0]          stable_cnt;
      logic [15:0]          duration;
      press_result_type     pending[$];
      int                   errors;
      int                   shorts;
      int                   longs;

      function new();
         debounce_thr = 16'd50;
         long_thr     = 16'd1000;
         prev_raw     = 1'b1;
         debounced    = 1'b1;
         held         = 1'b0;
         long_done    = 1'b0;
         stable_cnt   = '0;
         duration     = '0;
         errors       = 0;
         shorts       = 0;
         longs        = 0;
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function void note_tick(logic raw);
         press_result_type r;
         r.evt = EVT_NONE;
         if (held) duration = bump(duration);
         if (raw != prev_raw) stable_cnt = '0;
         else stable_cnt = bump(stable_cnt);
         prev_raw = raw;
         if (stable_cnt > debounce_thr && raw != debounced) begin
            debounced = raw;
            if (!raw) begin
               held      = 1'b1;
               long_done = 1'b0;
               duration  = '0;
            end else begin
               if (held && !long_done && duration > debounce_thr && duration < long_thr) begin
                  r.evt = EVT_SHORT;
               end
               held      = 1'b0;
               long_done = 1'b0;
               duration  = '0;
            end
         end
         // the long check runs on every held tick, bouncing or not
         if (held && !long_done && duration >= long_thr) begin
            long_done = 1'b1;
            r.evt     = EVT_LONG;
         end
         if (r.evt == EVT_SHORT) shorts++;
         if (r.evt == EVT_LONG) longs++;
         r.held  = held;
         r.ticks = held ? duration : '0;
         pending.push_back(r);
      endfunction

      function void check_result(logic [1:0] evt, logic is_held, logic [THR_WIDTH-1:0] ticks);
         press_result_type exp;
         if (pending.size() == 0) begin
            $error("result item with no tick pending");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (evt !== exp.evt) begin
            $error("press_event: expected %0d, got %0d", exp.evt, evt);
            errors++;
         end
         if (is_held !== exp.held) begin
            $error("is_held: expected %0d, got %0d", exp.held, is_held);
            errors++;
         end
         if (ticks !== exp.ticks) begin
            $error("held_ticks: expected %0d, got %0d", exp.ticks, ticks);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_raw_level;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_press_event;
   logic                 rsp_is_held;
   logic [THR_WIDTH-1:0] rsp_held_ticks;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [2:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   press_scoreboard sb = new();
   int stall_pct = 20;
   int ticks_sent = 0;
   int settings = 0;
   int quiet_cycles = 0;

   button_debounce_press_classifier DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_level   (req_raw_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_press_event (rsp_press_event),
      .rsp_is_held     (rsp_is_held),
      .rsp_held_ticks  (rsp_held_ticks),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: ready drops in random bursts while stall_pct is nonzero.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Note inputs before checking outputs so both see the same edge in a fixed order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_tick(req_raw_level);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_press_event, rsp_is_held, rsp_held_ticks);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Each task starts at a falling edge; send_tick returns right after its item is taken.
   task automatic send_tick(input logic raw);
      @(negedge clock);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_level <= raw;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   task automatic send_run(input logic raw, input int count);
      repeat (count) send_tick(raw);
   endtask

   task automatic hold_off_and_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [THR_WIDTH-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'h0000, val};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // read back through a second transfer
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'h0000, val}) begin
         $error("register %0d readback: expected %0d, got %0d", idx, val, prdata);
         sb.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_DEBOUNCE_TICKS) sb.debounce_thr = val;
      else sb.long_thr = val;
   endtask

   task automatic apply_thresholds(input logic [THR_WIDTH-1:0] deb, input logic [THR_WIDTH-1:0] lng);
      hold_off_and_drain();
      csr_write(REG_DEBOUNCE_TICKS, deb);
      csr_write(REG_LONG_PRESS_TICKS, lng);
      settings++;
   endtask

   // Mostly press/release patterns around the thresholds, sometimes plain noise.
   task automatic play_sequence();
      int unsigned deb;
      int unsigned lng;
      deb = sb.debounce_thr;
      lng = sb.long_thr;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
      end else begin
         repeat ($urandom_range(0, 3)) begin
            send_tick(1'b0);
            send_tick(1'b1);
         end
         // low run with an occasional glitch high
         repeat ($urandom_range(0, deb + lng + 4)) send_tick($urandom_range(0, 15) == 0);
         repeat ($urandom_range(0, 3)) begin
            send_tick(1'b1);
            send_tick(1'b0);
         end
         send_run(1'b1, int'($urandom_range(deb + 1, deb + 6)));
      end
   endtask

   initial begin
      int phase_start;
      bit paused;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_raw_level = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      paused        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-up thresholds: nothing debounces this quickly
      send_tick(1'b0);
      send_tick(1'b1);

      // zero long threshold: long press on the press tick, then silent release
      apply_thresholds(16'd0, 16'd0);
      send_run(1'b0, 2);
      send_run(1'b1, 2);

      // clean short press
      apply_thresholds(16'd1, 16'd10);
      send_run(1'b0, 6);
      send_run(1'b1, 3);

      // bounce during the press keeps the level from debouncing, so no press is reported
      apply_thresholds(16'd2, 16'd6);
      send_run(1'b0, 3);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_run(1'b1, 3);

      // debounce beyond the counter range: level never accepted
      apply_thresholds(16'hFFFF, 16'hFFFF);
      send_run(1'b0, 2);
      send_run(1'b1, 2);

      for (int phase = 0; phase < 4; phase++) begin
         apply_thresholds(THR_WIDTH'($urandom_range(0, 3)), THR_WIDTH'($urandom_range(1, 14)));
         if (phase == 3) stall_pct = 0;
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < 90) begin
            play_sequence();
            if (phase == 1 && !paused && ticks_sent - phase_start >= 50) begin
               hold_off_and_drain();
               paused = 1'b1;
            end
         end
      end

      hold_off_and_drain();
      repeat (10) @(negedge clock);
      $display("covered %0d ticks over %0d threshold settings incl. 0 and 65535 extremes",
               ticks_sent, settings);
      $display("predicted %0d short and %0d long presses", sb.shorts, sb.longs);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
